/* hw/rtl/quaternion_normalizer_macros.svh */
// Assertion macros for the quaternion normalizer.
`ifndef QUATERNION_NORMALIZER_MACROS_SVH
`define QUATERNION_NORMALIZER_MACROS_SVH
`ifndef SYNTH
`define QN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qn assertion failed");
`define QN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qn next-cycle assertion failed");
`else
`define QN_ASSERT(lbl, clk, rst_n, prop)
`define QN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/qn_pkg.sv */
package qn_pkg;

  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned MAG_W    = 32;
  localparam int unsigned SQ_W     = 64;
  localparam int unsigned FLOOR_W  = 20;
  localparam int unsigned WIN_W    = 40;
  localparam int unsigned D_W      = 38;
  localparam int unsigned RN_W     = 63;
  localparam int unsigned S_W      = 32;
  localparam int unsigned SQRT_N   = 32;
  localparam int unsigned SQRT_TOP = 62;
  localparam int unsigned RT_W     = 32;
  localparam int unsigned QN_W     = 62;
  localparam int unsigned QR_W     = 33;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned FRAC     = 29;

  localparam logic [WIN_W-1:0] WIN_RST = 40'd6073500000;
  localparam logic [SQ_W-1:0]  ONE_M   = 64'h0400_0000_0000_0000;

  localparam logic REG_SCALAR_FLOOR  = 1'b0;
  localparam logic REG_APPROX_WINDOW = 1'b1;

  typedef struct packed {
    logic [3:0]              neg;
    logic [3:0][MAG_W-1:0]   mag;
    logic                    degen;
    logic                    approx;
  } front_t;

  typedef struct packed {
    logic [3:0]              neg;
    logic [3:0][FIELD_W-1:0] early;
    logic [3:0]              ovf;
    logic                    use_div;
    logic                    approx;
    logic                    degen;
  } back_t;

  typedef struct packed {
    logic [3:0][FIELD_W-1:0] comp;
    logic                    approx;
    logic                    degen;
  } res_t;

endpackage

/* hw/rtl/qn_sqrt_cell.sv */
module qn_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [qn_pkg::SQ_W-1:0] rem_i,
  input  logic [qn_pkg::SQ_W-1:0] res_i,
  output logic [qn_pkg::SQ_W-1:0] rem_o,
  output logic [qn_pkg::SQ_W-1:0] res_o
);

  localparam int unsigned W = qn_pkg::SQ_W;
  localparam logic [W-1:0] ONE = 1;
  localparam logic [W-1:0] BIT = ONE << (qn_pkg::SQRT_TOP - 2 * STEP);

  logic [W-1:0] sum;
  logic [W-1:0] rem_d, res_d, rem_q, res_q;

  always_comb begin
    sum = res_i + BIT;
    if (rem_i >= sum) begin
      rem_d = rem_i - sum;
      res_d = (res_i >> 1) + BIT;
    end else begin
      rem_d = rem_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

  assign rem_o = rem_q;
  assign res_o = res_q;

endmodule

/* hw/rtl/qn_div_cell.sv */
module qn_div_cell #(
  parameter int unsigned REM_W = 63,
  parameter int unsigned DEN_W = 38,
  parameter int unsigned Q_W   = 32,
  parameter int unsigned SHIFT = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [Q_W-1:0]   q_i,
  output logic [REM_W-1:0] rem_o,
  output logic [DEN_W-1:0] den_o,
  output logic [Q_W-1:0]   q_o
);

  localparam int unsigned CMP_W = (REM_W > DEN_W + SHIFT) ? REM_W : DEN_W + SHIFT;

  logic [CMP_W-1:0] rem_x, sub_x, diff;
  logic             ge;
  logic [REM_W-1:0] rem_d, rem_q;
  logic [DEN_W-1:0] den_q;
  logic [Q_W-1:0]   q_d, q_q;

  assign rem_x = CMP_W'(rem_i);
  assign sub_x = CMP_W'(den_i) << SHIFT;
  assign ge    = rem_x >= sub_x;
  assign diff  = rem_x - sub_x;
  assign rem_d = ge ? REM_W'(diff) : rem_i;
  assign q_d   = {q_i[Q_W-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      q_q   <= q_d;
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign q_o   = q_q;

endmodule

/* hw/rtl/quaternion_normalizer.sv */
// channel   direction  beat taken when
// in        input      in_valid_i && in_ready_o
// out       output     out_valid_o && out_ready_i
// cfg       input      psel && penable && pwrite (pready tied high)
//
// One quaternion per cycle while in_ready_o is high.
// The pipeline runs through the 32-cell root chain and then the 33-cell divide chain.
// Reset clears the stage valids, the output buffer valids and the floor register, and sets the window to WIN_RST.
// A two-entry output buffer; in_ready_o drops only when both entries are held.
`include "quaternion_normalizer_macros.svh"

module quaternion_normalizer #(
  parameter int unsigned COMP_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] scalar_in_i,
  input  logic [31:0] vec_x_in_i,
  input  logic [31:0] vec_y_in_i,
  input  logic [31:0] vec_z_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] scalar_out_o,
  output logic [31:0] vec_x_out_o,
  output logic [31:0] vec_y_out_o,
  output logic [31:0] vec_z_out_o,
  output logic        approx_used_o,
  output logic        degenerate_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned FW   = qn_pkg::FIELD_W;
  localparam int unsigned MW   = qn_pkg::MAG_W;
  localparam int unsigned XW   = MW + 1;
  localparam int unsigned SQW  = qn_pkg::SQ_W;
  localparam int unsigned SUMW = SQW + 1;
  localparam int unsigned FLW  = qn_pkg::FLOOR_W;
  localparam int unsigned WW   = qn_pkg::WIN_W;
  localparam int unsigned DW   = qn_pkg::D_W;
  localparam int unsigned RNW  = qn_pkg::RN_W;
  localparam int unsigned SW   = qn_pkg::S_W;
  localparam int unsigned SQN  = qn_pkg::SQRT_N;
  localparam int unsigned RTW  = qn_pkg::RT_W;
  localparam int unsigned QNW  = qn_pkg::QN_W;
  localparam int unsigned QRW  = qn_pkg::QR_W;
  localparam int unsigned OVW  = RTW + QRW + 1;
  localparam int unsigned PDW  = qn_pkg::DATA_W;
  localparam int unsigned FRAC = qn_pkg::FRAC;
  localparam int unsigned CW   = (COMP_BITS < FW) ? COMP_BITS : FW;

  localparam logic [SQW-1:0] ONE64   = 1;
  localparam logic [SQW-1:0] LIM_NEG = ONE64 << (CW - 1);
  localparam logic [SQW-1:0] LIM_POS = LIM_NEG - ONE64;
  localparam logic [SQW-1:0] RND     = ONE64 << FRAC;
  localparam logic [RNW-1:0] RN_TOP  = RNW'(1) << (RNW - 1);

  function automatic logic [FW-1:0] sat_out(input logic neg, input logic [SQW-1:0] m);
    logic [SQW-1:0] lim;
    logic [SQW-1:0] c;
    lim = neg ? LIM_NEG : LIM_POS;
    c   = (m > lim) ? lim : m;
    return neg ? FW'(SQW'(0) - c) : FW'(c);
  endfunction

  // configuration
  logic [FLW-1:0] floor_q;
  logic [WW-1:0]  window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q  <= '0;
      window_q <= qn_pkg::WIN_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3])
        qn_pkg::REG_SCALAR_FLOOR:  floor_q  <= pwdata[FLW-1:0];
        qn_pkg::REG_APPROX_WINDOW: window_q <= pwdata[WW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      qn_pkg::REG_SCALAR_FLOOR:  prdata = PDW'(floor_q);
      qn_pkg::REG_APPROX_WINDOW: prdata = PDW'(window_q);
      default:                   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // flow control
  logic en;
  logic skid_v_q, out_valid_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // stage 1: sign and magnitude
  logic [3:0][FW-1:0] fin;
  logic [3:0][XW-1:0] ext, amag;
  qn_pkg::front_t     s1_d, s1_q;
  logic               s1_v_q;

  assign fin = {vec_z_in_i, vec_y_in_i, vec_x_in_i, scalar_in_i};

  always_comb begin
    s1_d = '0;
    for (int i = 0; i < 4; i++) begin
      ext[i]       = {{(XW - CW){fin[i][CW-1]}}, fin[i][CW-1:0]};
      s1_d.neg[i]  = fin[i][CW-1];
      amag[i]      = s1_d.neg[i] ? -ext[i] : ext[i];
      s1_d.mag[i]  = amag[i][MW-1:0];
    end
  end

  // stage 2: squares, stage 3: sum, stage 4: window and floor tests
  logic [3:0][SQW-1:0] sq_q;
  qn_pkg::front_t      s2_q, s3_q, s4_d, s4_q;
  logic                s2_v_q, s3_v_q, s4_v_q;
  logic [SUMW-1:0]     sum3, dsum4;
  logic [SQW-1:0]      m_q, m4_q, diff4;
  logic [DW-1:0]       d4_q;

  assign sum3 = SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]) + SUMW'(sq_q[3]);

  always_comb begin
    diff4       = (m_q >= qn_pkg::ONE_M) ? m_q - qn_pkg::ONE_M : qn_pkg::ONE_M - m_q;
    dsum4       = SUMW'(m_q) + SUMW'(qn_pkg::ONE_M);
    s4_d        = s3_q;
    s4_d.degen  = (s3_q.mag[0] <= MW'(floor_q)) || (m_q == '0);
    s4_d.approx = diff4 < SQW'(window_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= SQW'(s1_q.mag[i]) * SQW'(s1_q.mag[i]);
      end
      s2_q <= s1_q;
      m_q  <= sum3[SQW] ? '1 : sum3[SQW-1:0];
      s3_q <= s2_q;
      s4_q <= s4_d;
      m4_q <= m_q;
      d4_q <= dsum4[SUMW-1:SUMW-DW];
    end
  end

  // root and reciprocal chains
  logic [SQW-1:0] sr_rem [SQN+1];
  logic [SQW-1:0] sr_res [SQN+1];
  logic [RNW-1:0] rc_rem [SQN+1];
  logic [DW-1:0]  rc_den [SQN+1];
  logic [SW-1:0]  rc_quo [SQN+1];
  qn_pkg::front_t fp_q [SQN];
  logic [SQN-1:0] fv_q;

  assign sr_rem[0] = m4_q;
  assign sr_res[0] = '0;
  assign rc_rem[0] = RN_TOP | RNW'(d4_q >> 1);
  assign rc_den[0] = d4_q;
  assign rc_quo[0] = '0;

  for (genvar k = 0; k < SQN; k++) begin : g_root
    qn_sqrt_cell #(
      .STEP(k)
    ) u_sqrt (
      .clk_i(clk_i),
      .en_i (en),
      .rem_i(sr_rem[k]),
      .res_i(sr_res[k]),
      .rem_o(sr_rem[k+1]),
      .res_o(sr_res[k+1])
    );

    qn_div_cell #(
      .REM_W(RNW),
      .DEN_W(DW),
      .Q_W  (SW),
      .SHIFT(SW - 1 - k)
    ) u_recip (
      .clk_i(clk_i),
      .en_i (en),
      .rem_i(rc_rem[k]),
      .den_i(rc_den[k]),
      .q_i  (rc_quo[k]),
      .rem_o(rc_rem[k+1]),
      .den_o(rc_den[k+1]),
      .q_o  (rc_quo[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fp_q[0] <= s4_q;
      for (int k = 1; k < SQN; k++) begin
        fp_q[k] <= fp_q[k-1];
      end
    end
  end

  // stage P: divide setup and shortcut product
  logic [RTW-1:0]      res_p, r_p;
  logic [3:0][QNW-1:0] num_p, pnum_q;
  logic [3:0]          ovf_p, povf_q;
  logic [3:0][SQW-1:0] pprod_q;
  logic [RTW-1:0]      pr_q;
  qn_pkg::front_t      pf_q;
  logic                pv_q;

  assign res_p = sr_res[SQN][RTW-1:0];
  assign r_p   = (res_p == '0) ? RTW'(1) : res_p;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num_p[i] = (QNW'(fp_q[SQN-1].mag[i]) << FRAC) + QNW'(r_p >> 1);
      ovf_p[i] = OVW'(num_p[i]) >= (OVW'(r_p) << QRW);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        pprod_q[i] <= SQW'(fp_q[SQN-1].mag[i]) * SQW'(rc_quo[SQN]);
      end
      pnum_q <= num_p;
      povf_q <= ovf_p;
      pr_q   <= r_p;
      pf_q   <= fp_q[SQN-1];
    end
  end

  // stage Q: shortcut result, pass-through and path select
  qn_pkg::back_t       qb_d, qb_q;
  logic [3:0][QNW-1:0] qnum_q;
  logic [RTW-1:0]      qr_q;
  logic                qv_q;
  logic [3:0][SQW-1:0] rnd_q;
  logic [3:0][FW-1:0]  pass_q;

  always_comb begin
    qb_d.neg     = pf_q.neg;
    qb_d.ovf     = povf_q;
    qb_d.degen   = pf_q.degen;
    qb_d.approx  = pf_q.approx & ~pf_q.degen;
    qb_d.use_div = ~pf_q.degen & ~pf_q.approx;
    for (int i = 0; i < 4; i++) begin
      rnd_q[i]     = (pprod_q[i] + RND) >> (FRAC + 1);
      pass_q[i]    = pf_q.neg[i] ? FW'(-pf_q.mag[i]) : FW'(pf_q.mag[i]);
      qb_d.early[i] = pf_q.degen ? pass_q[i] : sat_out(pf_q.neg[i], rnd_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qb_q   <= qb_d;
      qnum_q <= pnum_q;
      qr_q   <= pr_q;
    end
  end

  // root-path divide lanes
  logic [QNW-1:0] dv_rem [4][QRW+1];
  logic [RTW-1:0] dv_den [4][QRW+1];
  logic [QRW-1:0] dv_quo [4][QRW+1];
  qn_pkg::back_t  bp_q [QRW];
  logic [QRW-1:0] bv_q;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    assign dv_rem[i][0] = qnum_q[i];
    assign dv_den[i][0] = qr_q;
    assign dv_quo[i][0] = '0;
    for (genvar k = 0; k < QRW; k++) begin : g_cell
      qn_div_cell #(
        .REM_W(QNW),
        .DEN_W(RTW),
        .Q_W  (QRW),
        .SHIFT(QRW - 1 - k)
      ) u_div (
        .clk_i(clk_i),
        .en_i (en),
        .rem_i(dv_rem[i][k]),
        .den_i(dv_den[i][k]),
        .q_i  (dv_quo[i][k]),
        .rem_o(dv_rem[i][k+1]),
        .den_o(dv_den[i][k+1]),
        .q_o  (dv_quo[i][k+1])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bp_q[0] <= qb_q;
      for (int k = 1; k < QRW; k++) begin
        bp_q[k] <= bp_q[k-1];
      end
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      fv_q   <= '0;
      pv_q   <= 1'b0;
      qv_q   <= 1'b0;
      bv_q   <= '0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      fv_q   <= {fv_q[SQN-2:0], s4_v_q};
      pv_q   <= fv_q[SQN-1];
      qv_q   <= pv_q;
      bv_q   <= {bv_q[QRW-2:0], qv_q};
    end
  end

  // final select and output buffer
  qn_pkg::back_t bl;
  qn_pkg::res_t  fin_res, out_q, skid_q;
  logic          last_v, take;

  assign bl     = bp_q[QRW-1];
  assign last_v = bv_q[QRW-1];
  assign take   = out_valid_q & out_ready_i;

  always_comb begin
    fin_res.approx = bl.approx;
    fin_res.degen  = bl.degen;
    for (int i = 0; i < 4; i++) begin
      fin_res.comp[i] = bl.use_div
                        ? sat_out(bl.neg[i], bl.ovf[i] ? '1 : SQW'(dv_quo[i][QRW]))
                        : bl.early[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_v_q    <= 1'b0;
    end else if (!out_valid_q || take) begin
      if (skid_v_q) begin
        out_valid_q <= 1'b1;
        skid_v_q    <= 1'b0;
      end else begin
        out_valid_q <= last_v;
      end
    end else if (last_v && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_q <= skid_v_q ? skid_q : fin_res;
    end else if (en) begin
      skid_q <= fin_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scalar_out_o  = out_q.comp[0];
  assign vec_x_out_o   = out_q.comp[1];
  assign vec_y_out_o   = out_q.comp[2];
  assign vec_z_out_o   = out_q.comp[3];
  assign approx_used_o = out_q.approx;
  assign degenerate_o  = out_q.degen;

  `QN_ASSERT(a_skid_behind_main, clk_i, rst_ni, skid_v_q |-> out_valid_q)
  `QN_ASSERT(a_one_path_flag, clk_i, rst_ni, out_valid_o |-> !(approx_used_o && degenerate_o))
  `QN_ASSERT_NEXT(a_stall_fills_skid, clk_i, rst_ni, out_valid_q && !out_ready_i && last_v && !skid_v_q, skid_v_q)

endmodule

/* tb/quaternion_normalizer_test.sv */
`timescale 1ns / 100ps

module quaternion_normalizer_test;

  localparam int unsigned CLK_HI = 6;
  localparam int unsigned CLK_LO = 6;
  localparam int unsigned LATENCY = 72;
  localparam int unsigned RAND_QUATS = 430;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam logic [63:0] UNIT_SQ = 64'h0400_0000_0000_0000;

  typedef struct packed {
    logic [31:0] s;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } quat_t;

  typedef struct packed {
    quat_t q;
    logic  approx;
    logic  degen;
  } norm_t;

  typedef struct {
    quat_t q;
    bit    known;
    norm_t want;
  } vec_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] scalar_in_i;
  logic [31:0] vec_x_in_i;
  logic [31:0] vec_y_in_i;
  logic [31:0] vec_z_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] scalar_out_o;
  logic [31:0] vec_x_out_o;
  logic [31:0] vec_y_out_o;
  logic [31:0] vec_z_out_o;
  logic        approx_used_o;
  logic        degenerate_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  logic [qn_pkg::FLOOR_W-1:0] floor_reg;
  logic [qn_pkg::WIN_W-1:0]   window_reg;
  norm_t              pending_norms[$];
  int unsigned        mismatches;
  longint unsigned    cycles;
  vec_row_t           rows[$];

  quaternion_normalizer uut (.*);

  always begin
    clk_i = 1'b1;
    #CLK_HI;
    clk_i = 1'b0;
    #CLK_LO;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp_comp(bit neg, logic [63:0] m);
    if (neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(64'd0 - m);
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return m[31:0];
  endfunction

  function automatic norm_t normalize(quat_t q);
    logic [31:0] c[4];
    logic [63:0] a[4];
    logic [64:0] acc;
    logic [63:0] msq, diff, d, sc, r;
    norm_t res;
    c[0] = q.s; c[1] = q.x; c[2] = q.y; c[3] = q.z;
    acc = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = c[i][31] ? 64'(-$signed({32'hFFFF_FFFF, c[i]})) : {32'd0, c[i]};
      acc = acc + a[i] * a[i];
    end
    msq = acc[64] ? '1 : acc[63:0];
    res = '0;
    if (a[0] <= {44'd0, floor_reg} || msq == 0) begin
      res.q = q;
      res.degen = 1'b1;
      return res;
    end
    diff = msq >= UNIT_SQ ? msq - UNIT_SQ : UNIT_SQ - msq;
    if (diff < {24'd0, window_reg}) begin
      d = (UNIT_SQ + msq) >> 27;
      sc = ((64'd1 << 62) + (d >> 1)) / d;
      for (int i = 0; i < 4; i++) c[i] = clamp_comp(c[i][31], (a[i] * sc + (64'd1 << 29)) >> 30);
      res.approx = 1'b1;
    end else begin
      r = root64(msq);
      if (r == 0) r = 1;
      for (int i = 0; i < 4; i++) c[i] = clamp_comp(c[i][31], ((a[i] << 29) + (r >> 1)) / r);
    end
    res.q = {c[0], c[1], c[2], c[3]};
    return res;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(logic [3:0] addr, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 4'(8 * qn_pkg::REG_SCALAR_FLOOR)) floor_reg = val[qn_pkg::FLOOR_W-1:0];
    else if (addr == 4'(8 * qn_pkg::REG_APPROX_WINDOW)) window_reg = val[qn_pkg::WIN_W-1:0];
  endtask

  task automatic drain();
    while (pending_norms.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic send_quat(quat_t q);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    scalar_in_i <= q.s; vec_x_in_i <= q.x; vec_y_in_i <= q.y; vec_z_in_i <= q.z;
    pending_norms.push_back(normalize(q));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] near_unit();
    int signed v;
    v = (1 << 29) + int'($urandom_range(0, 400)) - 200;
    return $urandom_range(0, 1) ? 32'(v) : 32'(-v);
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 29)) - (1 << 28));
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return 32'($urandom_range(0, 3000)) - 32'd1500;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic quat_t rand_quat();
    quat_t q;
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 3) begin
      q.s = near_unit();
      q.x = 32'($signed($urandom_range(0, 20000)) - 10000);
      q.y = 32'($signed($urandom_range(0, 20000)) - 10000);
      q.z = 32'($signed($urandom_range(0, 20000)) - 10000);
    end else begin
      q = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    end
    return q;
  endfunction

  always @(posedge clk_i) begin
    norm_t got, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.q = {scalar_out_o, vec_x_out_o, vec_y_out_o, vec_z_out_o};
        got.approx = approx_used_o;
        got.degen = degenerate_o;
        if (pending_norms.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output beat %h", got);
        end else begin
          want = pending_norms.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want s=%h x=%h y=%h z=%h a=%b d=%b got s=%h x=%h y=%h z=%h a=%b d=%b",
                want.q.s, want.q.x, want.q.y, want.q.z, want.approx, want.degen,
                got.q.s, got.q.x, got.q.y, got.q.z, got.approx, got.degen);
          end
        end
      end
      if ($urandom_range(0, 99) < 6) out_ready_i <= 1'b0;
      else if ($urandom_range(0, 99) < 30 || cycles[9:8] == 2'b01) out_ready_i <= 1'b1;
    end
  end

  task automatic run_rows();
    foreach (rows[i]) begin
      send_quat(rows[i].q);
      if (rows[i].known) pending_norms[pending_norms.size() - 1] = rows[i].want;
    end
    release_input();
    rows.delete();
  endtask

  function automatic vec_row_t row(quat_t q, bit known = 0, norm_t want = '0);
    vec_row_t r;
    r.q = q; r.known = known; r.want = want;
    return r;
  endfunction

  initial begin
    cycles = 0;
    mismatches = 0;
    floor_reg = '0;
    window_reg = qn_pkg::WIN_RST;
    in_valid_i = 1'b0;
    out_ready_i = 1'b1;
    scalar_in_i = '0; vec_x_in_i = '0; vec_y_in_i = '0; vec_z_in_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back(row('0, 1, {128'd0, 1'b0, 1'b1}));
    rows.push_back(row({32'h2000_0000, 96'd0}, 1, {32'h2000_0000, 96'd0, 1'b1, 1'b0}));
    rows.push_back(row({32'hE000_0000, 96'd0}, 1, {32'hE000_0000, 96'd0, 1'b1, 1'b0}));
    rows.push_back(row({32'd0, 32'h2000_0000, 64'd0}, 1,
                       {32'd0, 32'h2000_0000, 64'd0, 1'b0, 1'b1}));
    rows.push_back(row({4{32'h8000_0000}}));
    rows.push_back(row({4{32'h7FFF_FFFF}}));
    rows.push_back(row({32'h4000_0000, 96'd0}));
    rows.push_back(row({32'h1000_0000, 96'd0}));
    rows.push_back(row({32'd1, 96'd0}));
    rows.push_back(row({32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd5}));
    rows.push_back(row({32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 32'h1000_0000}));
    rows.push_back(row({32'hF000_0000, 32'h1000_0000, 32'hF000_0000, 32'h1000_0000}));
    rows.push_back(row({32'h2000_0100, 32'h0000_0200, 32'hFFFF_FE00, 32'd0}));
    rows.push_back(row({32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC}));
    run_rows();
    drain();

    write_reg(4'(8 * qn_pkg::REG_SCALAR_FLOOR), 64'hF_FFFF);
    write_reg(4'(8 * qn_pkg::REG_APPROX_WINDOW), 64'hFF_FFFF_FFFF);
    rows.push_back(row({32'h000F_FFFF, 32'h2000_0000, 64'd0}, 1,
                       {32'h000F_FFFF, 32'h2000_0000, 64'd0, 1'b0, 1'b1}));
    rows.push_back(row({32'hFFF0_0001, 96'd0}, 1, {32'hFFF0_0001, 96'd0, 1'b0, 1'b1}));
    rows.push_back(row({32'h0010_0000, 32'h2000_0000, 64'd0}));
    rows.push_back(row({32'h2000_0000, 96'd0}));
    rows.push_back(row({4{32'h7FFF_FFFF}}));
    run_rows();
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(4'(8 * qn_pkg::REG_SCALAR_FLOOR), 0);
                 write_reg(4'(8 * qn_pkg::REG_APPROX_WINDOW), qn_pkg::WIN_RST); end
        1: write_reg(4'(8 * qn_pkg::REG_APPROX_WINDOW), 0);
        2: begin write_reg(4'(8 * qn_pkg::REG_APPROX_WINDOW), 64'hFF_FFFF_FFFF);
                 write_reg(4'(8 * qn_pkg::REG_SCALAR_FLOOR), $urandom_range(0, 4000)); end
        3: begin write_reg(4'(8 * qn_pkg::REG_APPROX_WINDOW), {24'd0, $urandom, 8'd0} >> 8);
                 write_reg(4'(8 * qn_pkg::REG_SCALAR_FLOOR), $urandom_range(0, 20'hF_FFFF)); end
        default: begin write_reg(4'(8 * qn_pkg::REG_SCALAR_FLOOR), 0);
                       write_reg(4'(8 * qn_pkg::REG_APPROX_WINDOW), 64'd60_000_000_000); end
      endcase
      for (int i = 0; i < RAND_QUATS / 5; i++) send_quat(rand_quat());
      release_input();
      drain();
    end

    if (mismatches == 0 && pending_norms.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
